// ===== rtl/core/dtw_wavefront_distance_top_macros.svh =====
// ----------------------------------------------------------------------------
// dtw wavefront distance assertion macros
// property shorthands shared by the port checker
// ----------------------------------------------------------------------------
`ifndef DTW_WAVEFRONT_DISTANCE_TOP_MACROS_SVH
`define DTW_WAVEFRONT_DISTANCE_TOP_MACROS_SVH

// same-cycle implication, held off during reset
`define DTWWF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("dtw wavefront port check failed");

// next-cycle implication, held off during reset
`define DTWWF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("dtw wavefront port check failed");

`endif

// ===== rtl/core/dtwwf_pkg.sv =====
// ----------------------------------------------------------------------------
// dtwwf_pkg
// shared constants and types of the dtw wavefront distance block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dtwwf_pkg;

    // default configuration
    localparam int SEQ_LEN_DEF      = 16;
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int SUM_WIDTH_DEF    = 40;

    // fixed port widths
    localparam int SAMPLE_PORT_W = 16;
    localparam int SAMPLE_EXT_W  = 24;   // widest sample width
    localparam int STEP_W        = 5;
    localparam int ROUTE_W       = 32;
    localparam int DIST_W        = 40;

    // route direction codes
    typedef logic [1:0] dir_t;
    localparam dir_t DIR_DIAG  = 2'd0;
    localparam dir_t DIR_LEFT  = 2'd1;
    localparam dir_t DIR_ABOVE = 2'd2;

    // sequencer to cell row control
    typedef struct packed {
        logic clear;       // start of a run: zero the a line, sums to infinity
        logic shift_en;    // move the a samples one cell along
        logic step_en;     // commit one wavefront step
        logic first_step;  // step zero: origin of the grid is 0
    } ctrl_t;

endpackage

// ===== rtl/core/dtwwf_cell.sv =====
// ----------------------------------------------------------------------------
// dtwwf_cell
// one wavefront cell: squared difference, three-way minimum, saturating sum
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtwwf_cell #(
    parameter int SAMPLE_WIDTH = dtwwf_pkg::SAMPLE_WIDTH_DEF,
    parameter int SUM_WIDTH    = dtwwf_pkg::SUM_WIDTH_DEF
) (
    input  logic                           aclk,
    input  dtwwf_pkg::ctrl_t               ctrl,
    input  logic                           b_wr,
    input  logic signed [SAMPLE_WIDTH-1:0] b_in,
    input  logic signed [SAMPLE_WIDTH-1:0] a_in,
    input  logic        [SUM_WIDTH-1:0]    before_in,
    input  logic        [SUM_WIDTH-1:0]    prev_in,
    output logic signed [SAMPLE_WIDTH-1:0] a_out,
    output logic        [SUM_WIDTH-1:0]    before_out,
    output logic        [SUM_WIDTH-1:0]    prev_out,
    output logic        [SUM_WIDTH-1:0]    sum_out,
    output dtwwf_pkg::dir_t                dir_out
);

    localparam int MAG_W  = SAMPLE_WIDTH + 1;
    localparam int SQ_W   = 2 * MAG_W;
    localparam int WIDE_W = (SQ_W > SUM_WIDTH) ? SQ_W : SUM_WIDTH;
    localparam logic [SUM_WIDTH-1:0] SUM_MAX = '1;

    logic signed [SAMPLE_WIDTH-1:0] a_reg;
    logic signed [SAMPLE_WIDTH-1:0] b_reg;
    logic        [SUM_WIDTH-1:0]    sq_reg;
    logic        [SUM_WIDTH-1:0]    before_reg;
    logic        [SUM_WIDTH-1:0]    prev_reg;

    logic signed [MAG_W-1:0]     diff;
    logic        [MAG_W-1:0]     mag;
    logic        [SQ_W-1:0]      sq;
    logic        [SUM_WIDTH-1:0] sq_next;
    logic        [SUM_WIDTH-1:0] best;
    dtwwf_pkg::dir_t             dir;
    logic        [SUM_WIDTH:0]   add;
    logic        [SUM_WIDTH-1:0] sum_next;

    // square of the incoming sample against this cell's b, one step ahead
    always_comb begin
        diff    = MAG_W'(a_in) - MAG_W'(b_reg);
        mag     = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
        sq      = SQ_W'(mag) * SQ_W'(mag);
        sq_next = (WIDE_W'(sq) > WIDE_W'(SUM_MAX)) ? SUM_MAX : SUM_WIDTH'(sq);
    end

    // ties: diagonal, then left, then above
    always_comb begin
        best = before_in;
        dir  = dtwwf_pkg::DIR_DIAG;
        if (prev_in < best) begin
            best = prev_in;
            dir  = dtwwf_pkg::DIR_LEFT;
        end
        if (prev_reg < best) begin
            best = prev_reg;
            dir  = dtwwf_pkg::DIR_ABOVE;
        end
        add      = {1'b0, sq_reg} + {1'b0, best};
        sum_next = (sq_reg == SUM_MAX || best == SUM_MAX || add[SUM_WIDTH])
                   ? SUM_MAX : add[SUM_WIDTH-1:0];
    end

    always_ff @(posedge aclk) begin
        if (b_wr) begin
            b_reg <= b_in;
        end
        if (ctrl.clear) begin
            a_reg      <= '0;
            before_reg <= SUM_MAX;
            prev_reg   <= SUM_MAX;
        end else begin
            if (ctrl.shift_en) begin
                a_reg  <= a_in;
                sq_reg <= sq_next;
            end
            if (ctrl.step_en) begin
                before_reg <= prev_reg;
                prev_reg   <= sum_next;
            end
        end
    end

    assign a_out      = a_reg;
    assign before_out = before_reg;
    assign prev_out   = prev_reg;
    assign sum_out    = sum_next;
    assign dir_out    = dir;

endmodule

// ===== rtl/core/dtwwf_chain.sv =====
// ----------------------------------------------------------------------------
// dtwwf_chain
// row of wavefront cells with the grid boundary and route packing
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtwwf_chain #(
    parameter int SEQ_LEN      = dtwwf_pkg::SEQ_LEN_DEF,
    parameter int SAMPLE_WIDTH = dtwwf_pkg::SAMPLE_WIDTH_DEF,
    parameter int SUM_WIDTH    = dtwwf_pkg::SUM_WIDTH_DEF
) (
    input  logic                               aclk,
    input  dtwwf_pkg::ctrl_t                   ctrl,
    input  logic                               b_wr_en,
    input  logic        [$clog2(SEQ_LEN)-1:0]  b_wr_idx,
    input  logic signed [SAMPLE_WIDTH-1:0]     b_in,
    input  logic signed [SAMPLE_WIDTH-1:0]     a_feed,
    output logic        [dtwwf_pkg::ROUTE_W-1:0] route_word,
    output logic        [SUM_WIDTH-1:0]        final_sum
);

    localparam int RW = (2 * SEQ_LEN < dtwwf_pkg::ROUTE_W) ? 2 * SEQ_LEN
                                                           : dtwwf_pkg::ROUTE_W;
    localparam logic [SUM_WIDTH-1:0] SUM_MAX = '1;

    // lane 0 is the grid edge, lane c+1 belongs to cell c
    logic signed [SAMPLE_WIDTH-1:0] a_lane      [SEQ_LEN+1];
    logic        [SUM_WIDTH-1:0]    before_lane [SEQ_LEN+1];
    logic        [SUM_WIDTH-1:0]    prev_lane   [SEQ_LEN+1];
    logic        [SUM_WIDTH-1:0]    sum_lane    [SEQ_LEN];
    logic        [2*SEQ_LEN-1:0]    dir_all;

    assign a_lane[0]      = a_feed;
    assign before_lane[0] = ctrl.first_step ? '0 : SUM_MAX;
    assign prev_lane[0]   = SUM_MAX;

    for (genvar c = 0; c < SEQ_LEN; c++) begin : g_cell
        dtwwf_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .SUM_WIDTH    (SUM_WIDTH)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .b_wr       (b_wr_en && (b_wr_idx == ($clog2(SEQ_LEN))'(c))),
            .b_in       (b_in),
            .a_in       (a_lane[c]),
            .before_in  (before_lane[c]),
            .prev_in    (prev_lane[c]),
            .a_out      (a_lane[c+1]),
            .before_out (before_lane[c+1]),
            .prev_out   (prev_lane[c+1]),
            .sum_out    (sum_lane[c]),
            .dir_out    (dir_all[2*c +: 2])
        );
    end

    // only the first sixteen cells fit the route word
    assign route_word = dtwwf_pkg::ROUTE_W'(dir_all[RW-1:0]);
    assign final_sum  = sum_lane[SEQ_LEN-1];

endmodule

// ===== rtl/core/dtw_wavefront_distance_top.sv =====
// ----------------------------------------------------------------------------
// dtw_wavefront_distance_top
// dynamic time warping distance over a systolic row of wavefront cells
// ----------------------------------------------------------------------------
//   channel | ports                                        | direction
//   --------+----------------------------------------------+----------
//   input   | s_valid s_ready s_a_sample s_b_sample        | in
//           | s_last_pair                                  |
//   result  | m_valid m_ready m_step_index m_route_word    | out
//           | m_distance m_last_result                     |
//
// load words are taken while s_ready is high; the word with s_last_pair set
// starts a run: one store read, one priming shift, then one wavefront step per
// cycle while the output register is free, each step giving one result word
// (2*SEQ_LEN-1 in all) and covering one anti-diagonal in the single cell row
// a result word not taken holds the whole row until the output register
// frees; s_ready is low from the last pair until the final step commits
// aresetn is synchronous and clears control only; sample stores need no reset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module dtw_wavefront_distance_top #(
    parameter int SEQ_LEN      = dtwwf_pkg::SEQ_LEN_DEF,
    parameter int SAMPLE_WIDTH = dtwwf_pkg::SAMPLE_WIDTH_DEF,
    parameter int SUM_WIDTH    = dtwwf_pkg::SUM_WIDTH_DEF
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_valid,
    output logic                                     s_ready,
    input  logic signed [dtwwf_pkg::SAMPLE_PORT_W-1:0] s_a_sample,
    input  logic signed [dtwwf_pkg::SAMPLE_PORT_W-1:0] s_b_sample,
    input  logic                                     s_last_pair,
    output logic                                     m_valid,
    input  logic                                     m_ready,
    output logic        [dtwwf_pkg::STEP_W-1:0]      m_step_index,
    output logic        [dtwwf_pkg::ROUTE_W-1:0]     m_route_word,
    output logic        [dtwwf_pkg::DIST_W-1:0]      m_distance,
    output logic                                     m_last_result
);

    localparam int IDX_W  = $clog2(SEQ_LEN);
    localparam int T_W    = $clog2(2 * SEQ_LEN + 1);
    localparam int STEP_K = (T_W < dtwwf_pkg::STEP_W) ? T_W : dtwwf_pkg::STEP_W;
    localparam int DIST_K = (SUM_WIDTH < dtwwf_pkg::DIST_W) ? SUM_WIDTH
                                                            : dtwwf_pkg::DIST_W;
    localparam int EXT_PAD = dtwwf_pkg::SAMPLE_EXT_W - dtwwf_pkg::SAMPLE_PORT_W;
    localparam logic [T_W-1:0]   T_FIRST = T_W'(2);
    localparam logic [T_W-1:0]   T_LAST  = T_W'(2 * SEQ_LEN);
    localparam logic [IDX_W-1:0] IDX_TOP = IDX_W'(SEQ_LEN - 1);

    // control state
    logic             busy_reg;
    logic [T_W-1:0]   t_reg;        // run cycle: 0 read, 1 prime, 2.. steps
    logic [IDX_W-1:0] load_pos_reg;
    logic             m_valid_reg;

    // payload
    logic signed [SAMPLE_WIDTH-1:0]   a_store [SEQ_LEN];
    logic signed [SAMPLE_WIDTH-1:0]   a_rd_reg;
    logic [dtwwf_pkg::STEP_W-1:0]     m_step_index_reg;
    logic [dtwwf_pkg::ROUTE_W-1:0]    m_route_word_reg;
    logic [dtwwf_pkg::DIST_W-1:0]     m_distance_reg;
    logic                             m_last_result_reg;

    logic                              s_accept;
    logic                              advance;
    logic                              final_step;
    logic [dtwwf_pkg::SAMPLE_EXT_W-1:0] a_ext;
    logic [dtwwf_pkg::SAMPLE_EXT_W-1:0] b_ext;
    logic signed [SAMPLE_WIDTH-1:0]    a_sample;
    logic signed [SAMPLE_WIDTH-1:0]    b_sample;
    logic [IDX_W-1:0]                  load_pos_next;
    logic [IDX_W-1:0]                  rd_idx;
    logic [T_W-1:0]                    step_num;
    dtwwf_pkg::ctrl_t                  ctrl;
    logic [dtwwf_pkg::ROUTE_W-1:0]     route_word;
    logic [SUM_WIDTH-1:0]              final_sum;
    logic [dtwwf_pkg::STEP_W-1:0]      m_step_index_next;
    logic [dtwwf_pkg::DIST_W-1:0]      m_distance_next;

    // handshakes: loading only between runs, the row moves when the
    // output register is free
    assign s_ready    = !busy_reg;
    assign s_accept   = s_valid && s_ready;
    assign advance    = busy_reg && (!m_valid_reg || m_ready);
    assign final_step = (t_reg == T_LAST);

    // samples are the low SAMPLE_WIDTH bits, sign extended when wider
    assign a_ext    = {{EXT_PAD{s_a_sample[dtwwf_pkg::SAMPLE_PORT_W-1]}}, s_a_sample};
    assign b_ext    = {{EXT_PAD{s_b_sample[dtwwf_pkg::SAMPLE_PORT_W-1]}}, s_b_sample};
    assign a_sample = a_ext[SAMPLE_WIDTH-1:0];
    assign b_sample = b_ext[SAMPLE_WIDTH-1:0];

    // load position wraps, and a run always restarts it
    assign load_pos_next = (s_last_pair || load_pos_reg == IDX_TOP)
                           ? '0 : load_pos_reg + IDX_W'(1);

    // feed a[0..N-1], then keep repeating the last sample
    assign rd_idx = (t_reg >= T_W'(SEQ_LEN - 1)) ? IDX_TOP : t_reg[IDX_W-1:0];

    always_comb begin
        ctrl.clear      = s_accept && s_last_pair;
        ctrl.shift_en   = advance && (t_reg != '0);
        ctrl.step_en    = advance && (t_reg >= T_FIRST);
        ctrl.first_step = (t_reg == T_FIRST);
    end

    dtwwf_chain #(
        .SEQ_LEN      (SEQ_LEN),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .SUM_WIDTH    (SUM_WIDTH)
    ) u_chain (
        .aclk       (aclk),
        .ctrl       (ctrl),
        .b_wr_en    (s_accept),
        .b_wr_idx   (load_pos_reg),
        .b_in       (b_sample),
        .a_feed     (a_rd_reg),
        .route_word (route_word),
        .final_sum  (final_sum)
    );

    // result word fields; distance only on the final step
    assign step_num          = t_reg - T_FIRST;
    assign m_step_index_next = dtwwf_pkg::STEP_W'(step_num[STEP_K-1:0]);
    assign m_distance_next   = final_step
                               ? dtwwf_pkg::DIST_W'(final_sum[DIST_K-1:0]) : '0;

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            t_reg        <= '0;
            load_pos_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_accept) begin
                load_pos_reg <= load_pos_next;
                if (s_last_pair) begin
                    busy_reg <= 1'b1;
                    t_reg    <= '0;
                end
            end
            if (advance) begin
                t_reg <= t_reg + T_W'(1);
                if (final_step) begin
                    busy_reg <= 1'b0;
                end
            end
            if (ctrl.step_en) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // a sample store, its registered read port and the output word
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_store[load_pos_reg] <= a_sample;
        end
        if (advance) begin
            a_rd_reg <= a_store[rd_idx];
        end
        if (ctrl.step_en) begin
            m_step_index_reg  <= m_step_index_next;
            m_route_word_reg  <= route_word;
            m_distance_reg    <= m_distance_next;
            m_last_result_reg <= final_step;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_step_index  = m_step_index_reg;
    assign m_route_word  = m_route_word_reg;
    assign m_distance    = m_distance_reg;
    assign m_last_result = m_last_result_reg;

endmodule

// ===== rtl/core/dtwwf_chk.sv =====
// ----------------------------------------------------------------------------
// dtwwf_chk
// port-level checks of the dtw wavefront distance block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "dtw_wavefront_distance_top_macros.svh"

module dtwwf_chk #(
    parameter int SEQ_LEN = dtwwf_pkg::SEQ_LEN_DEF
) (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                s_last_pair,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [dtwwf_pkg::STEP_W-1:0]        m_step_index,
    input logic [dtwwf_pkg::ROUTE_W-1:0]       m_route_word,
    input logic [dtwwf_pkg::DIST_W-1:0]        m_distance,
    input logic                                m_last_result
);

    localparam logic [dtwwf_pkg::STEP_W-1:0] STEP_LAST =
        dtwwf_pkg::STEP_W'(2 * SEQ_LEN - 2);

    // a stalled result word holds
    `DTWWF_ASSERT_NXT(a_result_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_step_index) && $stable(m_route_word) && $stable(m_distance) && $stable(m_last_result))

    // taking the last pair closes the input
    `DTWWF_ASSERT_NXT(a_run_closes_input, aclk, aresetn, s_valid && s_ready && s_last_pair, !s_ready)

    // a pending result of an unfinished run keeps the input closed
    `DTWWF_ASSERT_IMP(a_mid_run_closed, aclk, aresetn, m_valid && !m_last_result, !s_ready)

    // distance is zero except on the closing word
    `DTWWF_ASSERT_IMP(a_distance_only_last, aclk, aresetn, m_valid && !m_last_result, m_distance == '0)

    // the closing word carries the last anti-diagonal
    `DTWWF_ASSERT_IMP(a_last_step_index, aclk, aresetn, m_valid && m_last_result, m_step_index == STEP_LAST)

endmodule

bind dtw_wavefront_distance_top dtwwf_chk #(
    .SEQ_LEN (SEQ_LEN)
) u_dtwwf_chk (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_last_pair   (s_last_pair),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_step_index  (m_step_index),
    .m_route_word  (m_route_word),
    .m_distance    (m_distance),
    .m_last_result (m_last_result)
);

// ===== dv/tb_dtw_wavefront_distance_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dtw_wavefront_distance_top
// self-checking bench for the dtw wavefront distance block: sample pairs go
// in over a valid/ready channel, and every step word that comes back is
// compared field by field with a wavefront model kept inside the bench
// ----------------------------------------------------------------------------

module tb_dtw_wavefront_distance_top;

    // geometry of the default build
    localparam int SEQ_N        = dtwwf_pkg::SEQ_LEN_DEF;
    localparam int SAMPLE_W     = dtwwf_pkg::SAMPLE_PORT_W;
    localparam int STEPS_PER_RUN = 2 * SEQ_N - 1;
    // one store read and one priming shift ahead of the steps, plus margin
    localparam int SETTLE_CYCLES = 2 * SEQ_N + 4;
    // the long receiver hold-off must stay well under the watchdog limit
    localparam int HOLD_CYCLES  = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_PAIRS  = 50;

    typedef logic [dtwwf_pkg::SUM_WIDTH_DEF-1:0] sum_t;
    typedef logic signed [SAMPLE_W-1:0]          sample_t;
    localparam sum_t SUM_INF = '1;

    // one step word as the result channel carries it
    typedef struct packed {
        logic [dtwwf_pkg::STEP_W-1:0]  step;
        logic [dtwwf_pkg::ROUTE_W-1:0] route;
        logic [dtwwf_pkg::DIST_W-1:0]  dist_val;
        logic                          last;
    } step_word_t;

    // one row of the directed stimulus: a pair repeated reps times, the
    // last repeat carrying s_last_pair; dist_known marks a distance that is
    // plain from the samples alone
    typedef struct packed {
        sample_t                      a;
        sample_t                      b;
        logic [5:0]                   reps;
        logic                         dist_known;
        logic [dtwwf_pkg::DIST_W-1:0] dist_val;
    } pair_row_t;

    // ------------------------------------------------------------------------
    // clock, reset and the ports of the block
    // ------------------------------------------------------------------------
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic                          s_valid     = 1'b0;
    logic                          s_ready;
    sample_t                       s_a_sample  = '0;
    sample_t                       s_b_sample  = '0;
    logic                          s_last_pair = 1'b0;
    logic                          m_valid;
    logic                          m_ready     = 1'b0;
    logic [dtwwf_pkg::STEP_W-1:0]  m_step_index;
    logic [dtwwf_pkg::ROUTE_W-1:0] m_route_word;
    logic [dtwwf_pkg::DIST_W-1:0]  m_distance;
    logic                          m_last_result;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    dtw_wavefront_distance_top dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_a_sample    (s_a_sample),
        .s_b_sample    (s_b_sample),
        .s_last_pair   (s_last_pair),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_step_index  (m_step_index),
        .m_route_word  (m_route_word),
        .m_distance    (m_distance),
        .m_last_result (m_last_result)
    );

    // ------------------------------------------------------------------------
    // wavefront model: sample stores, load position and the queue of step
    // words still owed by the block
    // ------------------------------------------------------------------------
    sample_t     seq_a_mem [SEQ_N];
    sample_t     seq_b_mem [SEQ_N];
    int unsigned load_pos = 0;
    step_word_t  expected_steps [$];

    // bookkeeping for the closing summary
    int errors        = 0;
    int pairs_sent    = 0;
    int runs_done     = 0;
    int runs_short    = 0;
    int runs_wrapped  = 0;
    int words_checked = 0;
    int input_stalls  = 0;
    int holds_done    = 0;

    // squared sample difference, formed one bit wider than a sample
    function automatic sum_t sq_cost(input sample_t x, input sample_t y);
        logic [SAMPLE_W:0] d;
        logic [SAMPLE_W:0] mag;
        logic [63:0]       sq;
        d   = {x[SAMPLE_W-1], x} - {y[SAMPLE_W-1], y};
        mag = d[SAMPLE_W] ? (~d + 1'b1) : d;
        sq  = 64'(mag) * 64'(mag);
        return (sq > 64'(SUM_INF)) ? SUM_INF : sum_t'(sq);
    endfunction

    // all-ones is infinity and absorbs everything
    function automatic sum_t sat_sum(input sum_t x, input sum_t y);
        if (x == SUM_INF || y == SUM_INF || x > SUM_INF - y)
            return SUM_INF;
        return x + y;
    endfunction

    // one full run of 2N-1 anti-diagonals over the stored samples
    function automatic void predict_warp_run();
        sum_t            sum_before [SEQ_N+1];
        sum_t            sum_prev   [SEQ_N+1];
        sum_t            sum_cur    [SEQ_N+1];
        sample_t         a_line     [SEQ_N];
        sum_t            best;
        dtwwf_pkg::dir_t dir;
        step_word_t      w;
        for (int i = 0; i <= SEQ_N; i++) begin
            sum_before[i] = SUM_INF;
            sum_prev[i]   = SUM_INF;
            sum_cur[i]    = SUM_INF;
        end
        sum_before[0] = '0;
        for (int i = 0; i < SEQ_N; i++)
            a_line[i] = '0;

        for (int s = 0; s < STEPS_PER_RUN; s++) begin
            // a samples march one cell along; beyond the end the line keeps
            // shifting in what it already holds at cell zero
            for (int p = SEQ_N - 1; p > 0; p--)
                a_line[p] = a_line[p-1];
            if (s < SEQ_N)
                a_line[0] = seq_a_mem[s];

            w.route = '0;
            for (int l = 1; l <= SEQ_N; l++) begin
                // tie order: diagonal, then left, then above
                best = sum_before[l-1];
                dir  = dtwwf_pkg::DIR_DIAG;
                if (sum_prev[l-1] < best) begin
                    best = sum_prev[l-1];
                    dir  = dtwwf_pkg::DIR_LEFT;
                end
                if (sum_prev[l] < best) begin
                    best = sum_prev[l];
                    dir  = dtwwf_pkg::DIR_ABOVE;
                end
                sum_cur[l] = sat_sum(sq_cost(a_line[l-1], seq_b_mem[l-1]), best);
                if (l - 1 < dtwwf_pkg::ROUTE_W / 2)
                    w.route[2*(l-1) +: 2] = dir;
            end

            w.step     = dtwwf_pkg::STEP_W'(s);
            w.last     = (s == STEPS_PER_RUN - 1);
            w.dist_val = w.last ? dtwwf_pkg::DIST_W'(sum_cur[SEQ_N]) : '0;
            expected_steps.push_back(w);

            for (int i = 0; i <= SEQ_N; i++) begin
                sum_before[i] = sum_prev[i];
                sum_prev[i]   = sum_cur[i];
            end
        end
        runs_done++;
    endfunction

    // a pair the block has taken: store it, and on the closing pair of a run
    // work out the whole run; the load position wraps and restarts per run
    function automatic void take_pair(input sample_t a, input sample_t b,
                                      input logic    closing);
        seq_a_mem[load_pos] = a;
        seq_b_mem[load_pos] = b;
        load_pos = (load_pos + 1) % SEQ_N;
        if (closing) begin
            predict_warp_run();
            load_pos = 0;
        end
    endfunction

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_ticket = 0;

    // offer one pair word, with random idle cycles ahead of it; valid stays
    // up with the payload steady until the block takes the word
    task automatic offer_pair(input sample_t a, input sample_t b,
                              input logic    closing);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_a_sample  <= a;
        s_b_sample  <= b;
        s_last_pair <= closing;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        take_pair(a, b, closing);
        pairs_sent++;
    endtask

    // sample source for the random runs; small spreads give lots of ties,
    // the edge values hit the extremes of the squared difference
    function automatic sample_t pick_sample(input int flavour);
        int f;
        f = (flavour > 3) ? $urandom_range(3) : flavour;
        case (f)
            0: return SAMPLE_W'($urandom);
            1: return SAMPLE_W'($urandom_range(8)) - SAMPLE_W'(4);
            2: begin
                case ($urandom_range(3))
                    0: return 16'sh8000;
                    1: return 16'sh7fff;
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: return SAMPLE_W'($urandom_range(2000)) - SAMPLE_W'(1000);
        endcase
    endfunction

    // hold the input back until every owed step word has come home
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_steps.size() != 0)
            @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // directed rows: the first one fills every store entry, so no later run
    // ever reads an entry that was never written
    // ------------------------------------------------------------------------
    pair_row_t pair_rows [4] = '{
        // widest possible gap on every cell: the straight diagonal of N cells
        '{a: 16'sh8000, b: 16'sh7fff, reps: 6'(SEQ_N), dist_known: 1'b1,
          dist_val: 40'h0f_ffe0_0010},
        // short run: only entry zero is replaced, with the gap reversed
        '{a: 16'sh7fff, b: 16'sh8000, reps: 6'd1, dist_known: 1'b0, dist_val: '0},
        // short run of equal samples at the head
        '{a: 16'sh0000, b: 16'sh0000, reps: 6'd2, dist_known: 1'b0, dist_val: '0},
        // short run of small opposite samples
        '{a: 16'shffff, b: 16'sh0001, reps: 6'd4, dist_known: 1'b0, dist_val: '0}
    };

    initial begin : stimulus
        int len;
        int flavour;
        int phase_pairs;

        // reset at the start, released once
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part
        foreach (pair_rows[r]) begin
            for (int k = 0; k < pair_rows[r].reps; k++)
                offer_pair(pair_rows[r].a, pair_rows[r].b, k == pair_rows[r].reps - 1);
            if (pair_rows[r].dist_known)
                expected_steps[expected_steps.size()-1].dist_val = pair_rows[r].dist_val;
            if (pair_rows[r].reps < SEQ_N)
                runs_short++;
        end
        wait_drained();

        // random part in three idling phases: receiver lazy, sender lazy,
        // then both flat out with one long receiver hold-off
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 27;
                    rx_idle_pct <= 61;
                end
                1: begin
                    tx_idle_pct = 61;
                    rx_idle_pct <= 27;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct <= 0;
                    // receiver stalls while the sender keeps offering, so the
                    // row fills and the input is pushed back
                    hold_ticket <= hold_ticket + 1;
                end
            endcase
            phase_pairs = 0;
            while (phase_pairs < PHASE_PAIRS) begin
                case ($urandom_range(99)) inside
                    [0:69]:  len = SEQ_N;
                    [70:84]: len = $urandom_range(SEQ_N - 1, 1);
                    default: len = $urandom_range(2 * SEQ_N + 8, SEQ_N + 1);
                endcase
                if (len < SEQ_N)
                    runs_short++;
                else if (len > SEQ_N)
                    runs_wrapped++;
                flavour = $urandom_range(4);
                for (int k = 0; k < len; k++)
                    offer_pair(pick_sample(flavour), pick_sample(flavour), k == len - 1);
                phase_pairs += len;
            end
            // sender pause until nothing is owed
            wait_drained();
        end

        // let anything stray show itself before closing
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (expected_steps.size() != 0) begin
            $display("%0t: %0d expected step words never arrived", $time,
                     expected_steps.size());
            errors++;
        end

        $display("run covered %0d pair words over %0d runs (%0d short, %0d wrapped)",
                 pairs_sent, runs_done, runs_short, runs_wrapped);
        $display("%0d step words checked, %0d long hold-offs, %0d input stall cycles",
                 words_checked, holds_done, input_stalls);
        if (errors == 0) begin
            $display("** dtw_wavefront_distance_top: PASSED **");
        end else begin
            $display("** dtw_wavefront_distance_top: FAILED **");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // result side: random ready, the long hold-off, and the word checker
    // ------------------------------------------------------------------------
    int hold_seen = 0;
    int hold_left = 0;

    task automatic check_field(input string name, input logic [63:0] exp_val,
                               input logic [63:0] got_val);
        if (exp_val !== got_val) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name,
                     exp_val, got_val);
            errors++;
        end
    endtask

    always @(posedge aclk) begin : result_side
        step_word_t w;
        if (aresetn && m_valid && m_ready) begin
            if (expected_steps.size() == 0) begin
                $display("%0t: unexpected step word, step %0d route 0x%0h", $time,
                         m_step_index, m_route_word);
                errors++;
            end else begin
                w = expected_steps.pop_front();
                check_field("step_index", 64'(w.step), 64'(m_step_index));
                check_field("route_word", 64'(w.route), 64'(m_route_word));
                check_field("distance", 64'(w.dist_val), 64'(m_distance));
                check_field("last_result", 64'(w.last), 64'(m_last_result));
                words_checked++;
            end
        end

        // the hold-off is counted here, independent of the sender
        if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left--;
        end else if (hold_seen != hold_ticket) begin
            hold_seen = hold_ticket;
            hold_left = HOLD_CYCLES;
            holds_done++;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: cycles with no word moving on either channel
    // ------------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge aclk) begin : watchdog
        if (aresetn) begin
            if (s_valid && !s_ready)
                input_stalls++;
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no word moved for %0d cycles, %0d step words still owed",
                         $time, quiet_cycles, expected_steps.size());
                $display("** dtw_wavefront_distance_top: FAILED **");
                $finish;
            end
        end
    end

endmodule
